// ----- design/circular_pattern_search_defines.svh -----
// Assertion helpers used by circular_pattern_search.
`ifndef CIRCULAR_PATTERN_SEARCH_DEFINES_SVH
`define CIRCULAR_PATTERN_SEARCH_DEFINES_SVH

`ifndef ASSERT_OFF
`define CPS_ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("invariant violated");
`define CPS_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication violated");
`define CPS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication violated");
`else
`define CPS_ASSERT_ALWAYS(label, clk, rst_n, cond)
`define CPS_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define CPS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ----- design/cps_pkg.sv -----
package cps_pkg;

    localparam int DEFAULT_TEXT_DEPTH = 64;
    localparam int SYM_W              = 8;
    localparam int POS_W              = 6;
    localparam int DATA_W             = 8;

    localparam logic FUNC_TEXT    = 1'b0;
    localparam logic FUNC_PATTERN = 1'b1;

    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] position;
        logic             last_result;
    } result_t;

endpackage

// ----- design/cps_out_reg.sv -----
module cps_out_reg (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       load,
    input  cps_pkg::result_t           res,
    output logic                       free,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [cps_pkg::DATA_W-1:0] m_tdata,   // [5:0] position, [7:6] zero
    output logic                       m_tuser,   // [0] found
    output logic                       m_tlast
);
    import cps_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    assign free       = !valid_reg || m_tready;
    assign valid_next = load || (valid_reg && !m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = DATA_W'(res_reg.position);
    assign m_tuser  = res_reg.found;
    assign m_tlast  = res_reg.last_result;

endmodule

// ----- design/circular_pattern_search.sv -----
// Text byte: accepted only in the idle state.
// Pattern byte: the text memory has one read port and is read one position per cycle,
// with a registered read into rdata_reg.
// Final pattern byte: then a scan of the candidates in ascending position, one candidate
// per cycle unless the output stalls. Reset is asynchronous and clears the control state
// and the candidate bits, but not fin_reg; the text memory is not cleared and needs no sweep.
`include "circular_pattern_search_defines.svh"

module circular_pattern_search #(
    parameter int TEXT_DEPTH = cps_pkg::DEFAULT_TEXT_DEPTH
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [cps_pkg::DATA_W-1:0] s_tdata,   // [7:0] symbol
    input  logic                       s_tuser,   // [0] func
    input  logic                       s_tlast,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [cps_pkg::DATA_W-1:0] m_tdata,   // [5:0] position, [7:6] zero
    output logic                       m_tuser,   // [0] found
    output logic                       m_tlast
);
    import cps_pkg::*;

    localparam int AW = (TEXT_DEPTH > 1) ? $clog2(TEXT_DEPTH) : 1;
    localparam int LW = $clog2(TEXT_DEPTH + 1);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_MATCH = 2'd1;
    localparam logic [1:0] ST_EMIT  = 2'd2;

    logic [1:0]            state_reg, state_next;
    logic [LW-1:0]         len_reg, len_next;
    logic [AW-1:0]         load_ptr_reg, load_ptr_next;
    logic                  load_full_reg, load_full_next;
    logic                  active_reg, active_next;
    logic [TEXT_DEPTH-1:0] cand_reg, cand_next;
    logic [SYM_W-1:0]      sym_reg, sym_next;
    logic                  fin_reg, fin_next;
    logic [LW-1:0]         rd_idx_reg, rd_idx_next;
    logic                  pipe_valid_reg, pipe_valid_next;
    logic [AW-1:0]         pipe_idx_reg, pipe_idx_next;
    logic                  hold_reg, hold_next;
    logic                  wrap_reg, wrap_next;
    logic [AW-1:0]         scan_reg, scan_next;

    logic [SYM_W-1:0]      text_mem [TEXT_DEPTH];
    logic [SYM_W-1:0]      rdata_reg;
    logic                  mem_we;
    logic                  mem_re;

    logic                  in_accept;
    logic                  out_free;
    logic                  out_load;
    result_t               out_res;
    logic [LW-1:0]         len_m1;
    logic [TEXT_DEPTH-1:0] beyond_len;

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign len_m1    = len_reg - LW'(1);

    always_comb
    begin
        for (int i = 0; i < TEXT_DEPTH; i++)
        begin
            beyond_len[i] = (LW'(i) >= len_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            text_mem[load_ptr_reg] <= s_tdata[SYM_W-1:0];
        end
        if (mem_re)
        begin
            rdata_reg <= text_mem[rd_idx_reg[AW-1:0]];
        end
    end

    always_comb
    begin
        logic [AW-1:0]         ptr_after;
        logic                  full_after;
        logic                  prev;
        logic [TEXT_DEPTH-1:0] cand_clr;

        state_next      = state_reg;
        len_next        = len_reg;
        load_ptr_next   = load_ptr_reg;
        load_full_next  = load_full_reg;
        active_next     = active_reg;
        cand_next       = cand_reg;
        sym_next        = sym_reg;
        fin_next        = fin_reg;
        rd_idx_next     = rd_idx_reg;
        pipe_valid_next = pipe_valid_reg;
        pipe_idx_next   = pipe_idx_reg;
        hold_next       = hold_reg;
        wrap_next       = wrap_reg;
        scan_next       = scan_reg;
        mem_we          = 1'b0;
        mem_re          = 1'b0;
        out_load        = 1'b0;
        out_res         = '0;
        ptr_after       = load_ptr_reg;
        full_after      = load_full_reg;
        prev            = 1'b0;
        cand_clr        = cand_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    if (s_tuser == FUNC_TEXT)
                    begin
                        // A text word abandons any pattern in progress.
                        if (active_reg)
                        begin
                            cand_next   = '0;
                            active_next = 1'b0;
                        end
                        if (!load_full_reg)
                        begin
                            mem_we = 1'b1;
                            if (load_ptr_reg == AW'(TEXT_DEPTH - 1))
                            begin
                                ptr_after  = '0;
                                full_after = 1'b1;
                            end
                            else
                            begin
                                ptr_after = load_ptr_reg + 1'b1;
                            end
                        end
                        if (s_tlast)
                        begin
                            len_next   = full_after ? LW'(TEXT_DEPTH) : LW'(ptr_after);
                            ptr_after  = '0;
                            full_after = 1'b0;
                        end
                        load_ptr_next  = ptr_after;
                        load_full_next = full_after;
                    end
                    else
                    begin
                        sym_next = s_tdata[SYM_W-1:0];
                        fin_next = s_tlast;
                        if (len_reg == '0)
                        begin
                            // Empty text: candidates are already all clear.
                            active_next = !s_tlast;
                            scan_next   = '0;
                            if (s_tlast)
                            begin
                                state_next = ST_EMIT;
                            end
                        end
                        else
                        begin
                            // Keep the old bit of the last position for the wrap-around.
                            wrap_next       = cand_reg[len_m1[AW-1:0]];
                            rd_idx_next     = '0;
                            pipe_valid_next = 1'b0;
                            state_next      = ST_MATCH;
                        end
                    end
                end
            end

            ST_MATCH:
            begin
                if (rd_idx_reg < len_reg)
                begin
                    mem_re          = 1'b1;
                    rd_idx_next     = rd_idx_reg + 1'b1;
                    pipe_valid_next = 1'b1;
                    pipe_idx_next   = rd_idx_reg[AW-1:0];
                end
                else
                begin
                    pipe_valid_next = 1'b0;
                end

                if (pipe_valid_reg)
                begin
                    // Positions are rewritten in ascending order, so the old bit of
                    // the previous position is carried in hold_reg.
                    if (!active_reg)
                    begin
                        prev = 1'b1;
                    end
                    else if (pipe_idx_reg == '0)
                    begin
                        prev = wrap_reg;
                    end
                    else
                    begin
                        prev = hold_reg;
                    end
                    hold_next               = cand_reg[pipe_idx_reg];
                    cand_next[pipe_idx_reg] = prev && (rdata_reg == sym_reg);
                    if (LW'(pipe_idx_reg) == len_m1)
                    begin
                        active_next = !fin_reg;
                        scan_next   = '0;
                        state_next  = fin_reg ? ST_EMIT : ST_IDLE;
                    end
                end
            end

            ST_EMIT:
            begin
                if (cand_reg == '0)
                begin
                    if (out_free)
                    begin
                        out_load            = 1'b1;
                        out_res.found       = 1'b0;
                        out_res.position    = '0;
                        out_res.last_result = 1'b1;
                        state_next          = ST_IDLE;
                    end
                end
                else if (cand_reg[scan_reg])
                begin
                    if (out_free)
                    begin
                        cand_clr[scan_reg]  = 1'b0;
                        out_load            = 1'b1;
                        out_res.found       = 1'b1;
                        out_res.position    = POS_W'(scan_reg);
                        out_res.last_result = (cand_clr == '0);
                        cand_next           = cand_clr;
                        scan_next           = scan_reg + 1'b1;
                        if (cand_clr == '0)
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                end
                else
                begin
                    scan_next = scan_reg + 1'b1;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            len_reg        <= '0;
            load_ptr_reg   <= '0;
            load_full_reg  <= 1'b0;
            active_reg     <= 1'b0;
            cand_reg       <= '0;
            rd_idx_reg     <= '0;
            pipe_valid_reg <= 1'b0;
            pipe_idx_reg   <= '0;
            scan_reg       <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            len_reg        <= len_next;
            load_ptr_reg   <= load_ptr_next;
            load_full_reg  <= load_full_next;
            active_reg     <= active_next;
            cand_reg       <= cand_next;
            rd_idx_reg     <= rd_idx_next;
            pipe_valid_reg <= pipe_valid_next;
            pipe_idx_reg   <= pipe_idx_next;
            scan_reg       <= scan_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sym_reg  <= sym_next;
        fin_reg  <= fin_next;
        hold_reg <= hold_next;
        wrap_reg <= wrap_next;
    end

    cps_out_reg u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (out_load),
        .res      (out_res),
        .free     (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    `CPS_ASSERT_ALWAYS(a_cand_in_text, clk, rst_n, (cand_reg & beyond_len) == '0)
    `CPS_ASSERT_IMPLIES(a_full_ptr_zero, clk, rst_n, load_full_reg, load_ptr_reg == '0)
    `CPS_ASSERT_IMPLIES(a_notfound_last, clk, rst_n, m_tvalid && !m_tuser, m_tlast)
    `CPS_ASSERT_NEXT(a_text_aborts, clk, rst_n, in_accept && (s_tuser == FUNC_TEXT), (cand_reg == '0) && !active_reg)

endmodule
